FILE: hdl/bpsc_pkg.sv
// bpsc_pkg: shared types and codes for the breakpoint and step control unit
// used by the slot cells, the controller and the top level; no dependencies

package bpsc_pkg;

	// widest slot index (up to 256 slots)
	localparam int IDX_W = 8;
	localparam int KEY_W = 24;
	localparam int LINE_W = 16;
	localparam int DEPTH_W = 10;

	// command codes carried in func
	localparam logic [3:0] FN_STMT     = 4'd0;
	localparam logic [3:0] FN_LOAD     = 4'd1;
	localparam logic [3:0] FN_RUN      = 4'd2;
	localparam logic [3:0] FN_STEP_IN  = 4'd3;
	localparam logic [3:0] FN_STEP_OV  = 4'd4;
	localparam logic [3:0] FN_STEP_OUT = 4'd5;
	localparam logic [3:0] FN_SET      = 4'd6;
	localparam logic [3:0] FN_DEL      = 4'd7;
	localparam logic [3:0] FN_CLR      = 4'd8;

	// status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_BAD_ST  = 2'd1;
	localparam logic [1:0] STS_NO_PROG = 2'd2;
	localparam logic [1:0] STS_FULL    = 2'd3;

	// marker for no pause line yet
	localparam logic [LINE_W:0] NO_LINE = '1;

	typedef enum logic [1:0] {
		SS_INIT    = 2'd0,
		SS_READY   = 2'd1,
		SS_RUNNING = 2'd2,
		SS_PAUSED  = 2'd3
	} sess_t;

	typedef enum logic [1:0] {
		SK_NONE = 2'd0,
		SK_INTO = 2'd1,
		SK_OVER = 2'd2,
		SK_OUT  = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		CS_IDLE  = 2'd0,
		CS_SWEEP = 2'd1,
		CS_DONE  = 2'd2
	} ctl_state_t;

	// search token walking down the slot chain
	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             free;
		logic [IDX_W-1:0] free_idx;
	} token_t;

	// slot update broadcast from the controller
	typedef struct packed {
		logic             en;
		logic             clr;
		logic             set;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] key;
	} slot_wr_t;

endpackage

FILE: hdl/bpsc_if.sv
// bpsc_if: valid/ready channel interfaces for commands and results
// no dependencies

interface bpsc_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic [7:0]  file_id;
	logic [15:0] line_no;
	logic [9:0]  call_depth;

	modport source(output valid, func, file_id, line_no, call_depth, input ready);
	modport sink(input valid, func, file_id, line_no, call_depth, output ready);
endinterface

interface bpsc_res_if;
	logic       valid;
	logic       ready;
	logic       paused;
	logic [1:0] status;
	logic [1:0] session_state;
	logic [4:0] bp_count;

	modport source(output valid, paused, status, session_state, bp_count, input ready);
	modport sink(input valid, paused, status, session_state, bp_count, output ready);
endinterface

FILE: hdl/bpsc_cell.sv
// bpsc_cell: one breakpoint slot; holds valid and key, updates the passing
// search token and registers it for the next slot; uses bpsc_pkg

module bpsc_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bpsc_pkg::token_t  tok_in,
	output bpsc_pkg::token_t  tok_out,
	input  bpsc_pkg::slot_wr_t wr
);
	import bpsc_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic             match;
	logic             empty;
	logic             vld_q;
	token_t           tok_q;
	token_t           tok_n;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	// compare against this slot and fold into the token
	assign match = valid_q && (key_q == tok_in.key);
	assign empty = !valid_q;

	always_comb begin
		tok_n = tok_in;
		if (!tok_in.hit && match) begin
			tok_n.hit     = 1'b1;
			tok_n.hit_idx = MY_IDX;
		end
		if (!tok_in.free && empty) begin
			tok_n.free     = 1'b1;
			tok_n.free_idx = MY_IDX;
		end
	end

	// token stage toward the next slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_n;
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

	// slot valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.clr) begin
			valid_q <= 1'b0;
		end else if (wr.en && wr.idx == MY_IDX) begin
			valid_q <= wr.set;
		end
	end

	// slot key, written only when the slot is filled
	always_ff @(posedge clk) begin
		if (wr.en && wr.set && wr.idx == MY_IDX) begin
			key_q <= wr.key;
		end
	end

endmodule

FILE: hdl/bpsc_ctrl.sv
// bpsc_ctrl: session and step state, command decode, slot updates and the
// result register; uses bpsc_pkg and the channel interfaces

module bpsc_ctrl #(
	parameter int CNT_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	bpsc_cmd_if.sink           cmd,
	bpsc_res_if.source         res,
	output bpsc_pkg::token_t   tok_first,
	input  bpsc_pkg::token_t   tok_last,
	output bpsc_pkg::slot_wr_t wr
);
	import bpsc_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_n;

	// held transaction
	logic [3:0]         func_q;
	logic [KEY_W-1:0]   key_q;
	logic [LINE_W-1:0]  line_q;
	logic [DEPTH_W-1:0] depth_q;
	token_t             srch_q;

	// session state
	sess_t              mode_q, mode_n;
	step_t              step_q, step_n;
	logic [DEPTH_W-1:0] start_q, start_n;
	logic [LINE_W:0]    last_q, last_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;

	// result register
	logic               ovld_q;
	logic               paused_q, paused_n;
	logic [1:0]         status_q, status_n;
	logic [CNT_W+4:0]   cnt_ext;

	logic               accept;
	logic               commit;
	logic               hit;
	slot_wr_t           wr_n;

	assign accept = cmd.valid && cmd.ready;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			CS_IDLE:  if (accept) state_n = CS_SWEEP;
			CS_SWEEP: if (tok_last.vld) state_n = CS_DONE;
			CS_DONE:  if (!ovld_q || res.ready) state_n = CS_IDLE;
			default:  state_n = CS_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd.ready = 1'b0;
		commit    = 1'b0;
		case (state_q)
			CS_IDLE:  cmd.ready = 1'b1;
			CS_SWEEP: commit = 1'b0;
			CS_DONE:  commit = !ovld_q || res.ready;
			default:  commit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// launch the search token with the transaction key
	always_comb begin
		tok_first          = '0;
		tok_first.vld      = accept;
		tok_first.key      = {cmd.file_id, cmd.line_no};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= cmd.func;
			key_q   <= {cmd.file_id, cmd.line_no};
			line_q  <= cmd.line_no;
			depth_q <= cmd.call_depth;
		end
		if (tok_last.vld) begin
			srch_q <= tok_last;
		end
	end

	// pause decision for a statement event
	always_comb begin
		case (step_q)
			SK_INTO: hit = 1'b1;
			SK_OVER: hit = (depth_q < start_q) ||
				(depth_q == start_q && {1'b0, line_q} != last_q);
			SK_OUT:  hit = depth_q < start_q;
			default: hit = srch_q.hit;
		endcase
	end

	// command decode
	always_comb begin
		mode_n   = mode_q;
		step_n   = step_q;
		start_n  = start_q;
		last_n   = last_q;
		cnt_n    = cnt_q;
		paused_n = 1'b0;
		status_n = STS_OK;
		wr_n     = '0;
		wr_n.key = key_q;
		case (func_q)
			FN_STMT: begin
				if (mode_q == SS_RUNNING && hit) begin
					paused_n = 1'b1;
					mode_n   = SS_PAUSED;
					step_n   = SK_NONE;
					last_n   = {1'b0, line_q};
				end
			end
			FN_LOAD: begin
				if (mode_q == SS_INIT) mode_n = SS_READY;
				else status_n = STS_BAD_ST;
			end
			FN_RUN: begin
				if (mode_q == SS_INIT) status_n = STS_NO_PROG;
				else mode_n = SS_RUNNING;
			end
			FN_STEP_IN: begin
				if (mode_q == SS_PAUSED) begin
					step_n  = SK_INTO;
					start_n = depth_q;
					mode_n  = SS_RUNNING;
				end else if (mode_q == SS_READY) begin
					step_n  = SK_INTO;
					start_n = '0;
					last_n  = NO_LINE;
					mode_n  = SS_RUNNING;
				end else begin
					status_n = STS_BAD_ST;
				end
			end
			FN_STEP_OV, FN_STEP_OUT: begin
				if (mode_q == SS_PAUSED) begin
					step_n  = (func_q == FN_STEP_OV) ? SK_OVER : SK_OUT;
					start_n = depth_q;
					mode_n  = SS_RUNNING;
				end else begin
					status_n = STS_BAD_ST;
				end
			end
			FN_SET: begin
				if (!srch_q.hit) begin
					if (srch_q.free) begin
						wr_n.en  = 1'b1;
						wr_n.set = 1'b1;
						wr_n.idx = srch_q.free_idx;
						cnt_n    = cnt_q + 1'b1;
					end else begin
						status_n = STS_FULL;
					end
				end
			end
			FN_DEL: begin
				if (srch_q.hit) begin
					wr_n.en  = 1'b1;
					wr_n.idx = srch_q.hit_idx;
					cnt_n    = cnt_q - 1'b1;
				end
			end
			FN_CLR: begin
				wr_n.clr = 1'b1;
				cnt_n    = '0;
			end
			default: status_n = STS_OK;
		endcase
	end

	// slot update only on commit
	always_comb begin
		wr     = wr_n;
		wr.en  = wr_n.en && commit;
		wr.clr = wr_n.clr && commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= SS_INIT;
			step_q  <= SK_NONE;
			start_q <= '0;
			last_q  <= NO_LINE;
			cnt_q   <= '0;
		end else if (commit) begin
			mode_q  <= mode_n;
			step_q  <= step_n;
			start_q <= start_n;
			last_q  <= last_n;
			cnt_q   <= cnt_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (commit) begin
			ovld_q <= 1'b1;
		end else if (res.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			paused_q <= paused_n;
			status_q <= status_n;
		end
	end

	assign cnt_ext           = {5'b0, cnt_q};
	assign res.valid         = ovld_q;
	assign res.paused        = paused_q;
	assign res.status        = status_q;
	assign res.session_state = mode_q;
	assign res.bp_count      = cnt_ext[4:0];

endmodule

FILE: hdl/breakpoint_step_control_unit.sv
// breakpoint_step_control_unit: top level, chain of breakpoint slot cells
// and the session controller; uses bpsc_pkg, bpsc_if, bpsc_cell, bpsc_ctrl
//
// Usage:
//   cmd carries one command or statement event per transaction (func,
//   file_id, line_no, call_depth); res returns exactly one result per
//   transaction (paused, status, session_state, bp_count), in order.
//   Each transaction sends a search token down the row of BP_SLOTS slot
//   cells, one cell per cycle, collecting the first matching slot and the
//   first free slot. The controller then applies the command and loads the
//   result register. One transaction is in flight at a time, so a new one
//   is taken only once the last one has committed its result.
//   Reset clears the session to init, the step mode to none, the pause line
//   to no line and every slot valid bit; slot keys are left as they are.
//   When res stalls, the finished result holds in its register and the next
//   transaction waits in the controller before commit, so nothing is lost.

module breakpoint_step_control_unit #(
	parameter int BP_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	bpsc_cmd_if.sink   cmd,
	bpsc_res_if.source res
);
	import bpsc_pkg::*;

	localparam int CNT_W = $clog2(BP_SLOTS + 1);

	token_t                tok [BP_SLOTS+1];
	slot_wr_t              wr;
	logic [BP_SLOTS-1:0]   tok_vld;

	bpsc_ctrl #(
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res      (res),
		.tok_first(tok[0]),
		.tok_last (tok[BP_SLOTS]),
		.wr       (wr)
	);

	// slot row
	for (genvar i = 0; i < BP_SLOTS; i++) begin : g_slot
		bpsc_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[i]),
			.tok_out(tok[i+1]),
			.wr     (wr)
		);
		assign tok_vld[i] = tok[i+1].vld;
	end

	// one transaction at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command taken while another is in flight");

	// at most one search token in the slot row
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one search token in the slot row");

	// token leaving the row never meets an open command port
	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok[BP_SLOTS].vld |-> !cmd.ready)
		else $error("search finished while controller idle");

	// count stays within the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (BP_SLOTS > 31) || (32'(res.bp_count) <= 32'(BP_SLOTS)))
		else $error("breakpoint count beyond table size");

endmodule
